[rtl/core/sspq_pkg.sv]
package sspq_pkg;

    localparam int PRIO_W    = 16;
    localparam int PAYLOAD_W = 16;
    localparam int COUNT_W   = 5;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [PRIO_W-1:0] prio;
        entry_t            entry;
    } cmd_t;

endpackage

[rtl/core/sspq_cell.sv]
module sspq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic            clk,
    input  sspq_pkg::cmd_t  cmd,
    input  logic [CW-1:0]   count,
    input  logic            prev_ge,
    input  sspq_pkg::entry_t prev_entry,
    input  sspq_pkg::entry_t next_entry,
    output logic            ge,
    output sspq_pkg::entry_t entry
);
    import sspq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    assign occupied = CW'(IDX) < count;
    assign ge       = occupied && (entry_reg.prio >= cmd.prio);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.push)
        begin
            if (ge)
            begin
                entry_next = entry_reg;
            end
            else if (prev_ge)
            begin
                entry_next = cmd.entry;
            end
            else
            begin
                entry_next = prev_entry;
            end
        end
        else if (cmd.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[rtl/core/stable_sorted_priority_queue.sv]
// Stable sorted priority queue of DEPTH entries held in a row of cells, head at cell 0.
// Each cell compares its own priority with a pushed one and keeps its entry or takes the
// new entry, its left neighbor's entry or its right neighbor's entry. An item is taken
// every cycle while the result register is free or being drained; its result is
// registered and appears in the cycle after the transfer. Ties leave in arrival order.
// A push to a full queue and a pop from an empty one leave the queue as it was and are
// reported in status; entry_count shows the low 5 bits of the count after the item.
module stable_sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // priority_in[15:0], payload_in[31:16]
    input  logic [0:0]  s_tuser,  // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // priority_out[15:0], payload_out[31:16],
                                  // entry_count[36:32], zero[39:37]
    output logic [1:0]  m_tuser   // status[1:0]
);
    import sspq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           out_valid_reg;
    status_t        status_reg;
    status_t        status_next;
    entry_t         out_entry_reg;
    entry_t         out_entry_next;
    logic [CW-1:0]  out_count_reg;

    logic           accept;
    logic           is_pop;
    logic           full;
    logic           empty;
    cmd_t           cmd;
    entry_t         cell_q   [DEPTH];
    entry_t         prev_e_w [DEPTH];
    entry_t         next_e_w [DEPTH];
    logic [DEPTH-1:0] ge_w;
    logic [DEPTH-1:0] prev_ge_w;
    logic [CW+4:0]  count_ext;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_pop   = s_tuser[0];
    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;

    assign cmd.push          = accept && !is_pop && !full;
    assign cmd.pop           = accept && is_pop && !empty;
    assign cmd.prio          = s_tdata[15:0];
    assign cmd.entry.prio    = s_tdata[15:0];
    assign cmd.entry.payload = s_tdata[31:16];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign prev_ge_w[i] = 1'b1;
            assign prev_e_w[i]  = cmd.entry;
        end
        else
        begin : g_body
            assign prev_ge_w[i] = ge_w[i-1];
            assign prev_e_w[i]  = cell_q[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign next_e_w[i] = cell_q[i];
        end
        else
        begin : g_mid
            assign next_e_w[i] = cell_q[i+1];
        end

        sspq_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .prev_ge    (prev_ge_w[i]),
            .prev_entry (prev_e_w[i]),
            .next_entry (next_e_w[i]),
            .ge         (ge_w[i]),
            .entry      (cell_q[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        status_next    = ST_DONE;
        out_entry_next = '0;
        if (is_pop)
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                out_entry_next = cell_q[0];
                count_next     = count_reg - CW'(1);
            end
        end
        else
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_entry_reg <= out_entry_next;
            out_count_reg <= count_next;
        end
    end

    assign count_ext = {5'd0, out_count_reg};
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = status_reg;
    assign m_tdata   = {3'd0, count_ext[4:0], out_entry_reg.payload, out_entry_reg.prio};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_pop && full |=> count_reg == $past(count_reg))
        else $error("dropped push changed the count");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_pop && !empty |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not decrement the count");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid && out_count_reg == count_reg)
        else $error("transfer produced no matching result");
`endif

endmodule

[sim/tb_stable_sorted_priority_queue.sv]
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue;

    import sspq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef struct packed {
        status_t              status;
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload;
        logic [COUNT_W-1:0]   count;
    } result_t;

    typedef struct packed {
        logic                 act;
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload;
        logic                 known;
        result_t              want;
    } stim_row_t;

    localparam int NUM_ROWS = 24;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ACT_POP,  16'h0000, 16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 5'd1}},
        '{ACT_PUSH, 16'h0000, 16'h0000, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 5'd2}},
        '{ACT_PUSH, 16'h8000, 16'h0001, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h8000, 16'h0002, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h8000, 16'h0003, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h0001, 16'hAAAA, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'hFFFF, 16'h5555, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h7FFF, 16'h00FF, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h8001, 16'hFF00, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h0000, 16'h1234, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h1234, 16'h8000, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'hFFFE, 16'h0F0F, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h8000, 16'h0004, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h0002, 16'hF0F0, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h4000, 16'h3C3C, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h0000, 16'hC3C3, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'hFFFF, 16'h0000, 1'b1, '{ST_FULL,  16'h0000, 16'h0000, 5'd16}},
        '{ACT_POP,  16'h0000, 16'h0000, 1'b1, '{ST_DONE,  16'hFFFF, 16'hFFFF, 5'd15}},
        '{ACT_POP,  16'hFFFF, 16'hFFFF, 1'b1, '{ST_DONE,  16'hFFFF, 16'h5555, 5'd14}},
        '{ACT_POP,  16'h0000, 16'h0000, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_POP,  16'h0000, 16'h0000, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_POP,  16'h0000, 16'h0000, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}},
        '{ACT_PUSH, 16'h8000, 16'h0005, 1'b0, '{ST_DONE,  16'h0000, 16'h0000, 5'd0}}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    logic        item_known;
    result_t     item_want;

    entry_t      sorted_entries [DEPTH];
    int          held;
    result_t     expected_results [$];

    int          src_idle_pct;
    int          sink_stall_pct;
    int          error_count;
    int          cycle_count;

    stable_sorted_priority_queue #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic result_t queue_step(logic act, logic [PRIO_W-1:0] prio,
                                           logic [PAYLOAD_W-1:0] payload);
        result_t r;
        int      pos;
        int      i;
        r        = '0;
        r.status = ST_DONE;
        if (act == ACT_PUSH)
        begin
            if (held >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < held && sorted_entries[pos].prio >= prio)
                begin
                    pos++;
                end
                for (i = held; i > pos; i--)
                begin
                    sorted_entries[i] = sorted_entries[i-1];
                end
                sorted_entries[pos].prio    = prio;
                sorted_entries[pos].payload = payload;
                held++;
            end
        end
        else
        begin
            if (held == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.prio    = sorted_entries[0].prio;
                r.payload = sorted_entries[0].payload;
                for (i = 1; i < held; i++)
                begin
                    sorted_entries[i-1] = sorted_entries[i];
                end
                held--;
            end
        end
        r.count = COUNT_W'(held);
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_stable_sorted_priority_queue: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        result_t predicted;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status  = status_t'(m_tuser);
                got.prio    = m_tdata[15:0];
                got.payload = m_tdata[31:16];
                got.count   = m_tdata[36:32];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 16'(want.status), 16'(got.status));
                    check_field("priority_out", want.prio, got.prio);
                    check_field("payload_out", want.payload, got.payload);
                    check_field("entry_count", 16'(want.count), 16'(got.count));
                end
            end
            if (s_tvalid && s_tready)
            begin
                predicted = queue_step(s_tuser[0], s_tdata[15:0], s_tdata[31:16]);
                expected_results.push_back(item_known ? item_want : predicted);
            end
        end
    end

    task automatic send_item(logic act, logic [15:0] prio, logic [15:0] payload,
                             logic known, result_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= act;
        s_tdata    <= {payload, prio};
        item_known <= known;
        item_want  <= want;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_prio();
        int kind;
        kind = $urandom_range(9);
        if (kind < 4)
        begin
            return 16'($urandom_range(3));
        end
        else if (kind < 5)
        begin
            return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    initial
    begin : stimulus
        int n;
        int push_pct;
        int run_left;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        item_known     = 1'b0;
        item_want      = '0;
        rst_n          = 1'b0;
        held           = 0;
        error_count    = 0;
        cycle_count    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        push_pct       = 50;
        run_left       = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (n = 0; n < NUM_ROWS; n++)
        begin
            send_item(DIRECTED_ROWS[n].act, DIRECTED_ROWS[n].prio,
                      DIRECTED_ROWS[n].payload, DIRECTED_ROWS[n].known,
                      DIRECTED_ROWS[n].want);
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ((n * 4) / RANDOM_ITEMS)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
                default: begin src_idle_pct = 13; sink_stall_pct = 13; end
            endcase
            // pick random filling, draining or mixed runs to reach full and empty
            if (run_left == 0)
            begin
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                run_left = $urandom_range(60, 20);
            end
            run_left--;
            send_item(($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP,
                      pick_prio(), 16'($urandom), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("tb_stable_sorted_priority_queue: PASS");
        end
        else
        begin
            $display("tb_stable_sorted_priority_queue: FAIL");
        end
        $finish;
    end

endmodule
